// ===== rtl/rau_pkg.sv =====
package rau_pkg;

    localparam int unsigned VALUE_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_LT  = 3'd4,
        OP_EQ  = 3'd5
    } op_code_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_code_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] num_a;
        logic signed [31:0] den_a;
        logic signed [31:0] num_b;
        logic signed [31:0] den_b;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               compare_true;
        logic [1:0]         status;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } unit_ctl_t;

endpackage

// ===== rtl/rau_divider.sv =====
module rau_divider #(
    parameter int unsigned W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    import rau_pkg::*;

    localparam int unsigned CW = $clog2(W + 1);

    logic [CW-1:0] count_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  dsr_reg;
    logic [W:0]    trial;

    assign trial = {rem_reg, quo_reg[W-1]} - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CW'(W);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[W-2:0], quo_reg[W-1]};
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

// ===== rtl/rau_multiplier.sv =====
module rau_multiplier (
    input  logic        clk,
    input  logic        start,
    input  logic [31:0] mul_a,
    input  logic [31:0] mul_b,
    output logic [63:0] product
);
    import rau_pkg::*;

    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (start)
            prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    assign product = prod_reg;
endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: one item at a time through a shared 64-bit divider.
// Unknown operations and zero denominators go straight from operand capture to output.
// Otherwise the divider makes one pass per Euclid step and two per reduction of a, b and,
// except for compares, the result; each product is a separate multiplier pass.
// A new item is taken only once the last is through and the unit is idle; in_ready is low meanwhile.
// Reset: rst_n asynchronous, active low; sequencer idle, no result pending.
module rational_arithmetic_unit #(
    parameter int unsigned VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rau_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rau_pkg::out_item_t  out_data
);
    import rau_pkg::*;

    localparam int unsigned VW = VALUE_WIDTH;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_OPND   = 12'b000000000010,
        S_GCD    = 12'b000000000100,
        S_GWAIT  = 12'b000000001000,
        S_RDIV1  = 12'b000000010000,
        S_RWAIT1 = 12'b000000100000,
        S_RDIV2  = 12'b000001000000,
        S_RWAIT2 = 12'b000010000000,
        S_MUL    = 12'b000100000000,
        S_MWAIT  = 12'b001000000000,
        S_COMB   = 12'b010000000000,
        S_OUT    = 12'b100000000000
    } state_t;

    state_t      state_reg, state_next;
    in_item_t    item_reg;
    logic [1:0]  phase_reg;
    logic        a_neg_reg, b_neg_reg, r_neg_reg;
    logic [63:0] a_mag_reg, a_den_reg, b_mag_reg, b_den_reg;
    logic [63:0] r_mag_reg, r_den_reg;
    logic [63:0] g_x_reg, g_y_reg;
    logic [63:0] p0_reg, p1_reg;
    logic [1:0]  mstep_reg;
    out_item_t   work_reg;
    out_item_t   out_reg;
    out_item_t   fin_item;
    logic        out_valid_reg;

    logic        div_start, div_busy, div_done;
    logic [63:0] div_dividend, div_divisor, div_q, div_r;
    logic        mul_start;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    unit_ctl_t   div_ctl;

    rau_divider #(.W(64)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    rau_multiplier u_mul (
        .clk     (clk),
        .start   (mul_start),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .product (mul_p)
    );

    assign div_ctl = '{start: div_start, busy: div_busy, done: div_done};

    function automatic logic signed [VW:0] take_val(input logic [31:0] raw);
        take_val = (VW+1)'(signed'(raw[VW-1:0]));
    endfunction

    logic signed [VW:0] na_s, da_s, nb_s, db_s;
    logic signed [VW:0] nan, dan, nbn, dbn;

    always_comb
    begin
        na_s = take_val(item_reg.num_a);
        da_s = take_val(item_reg.den_a);
        nb_s = take_val(item_reg.num_b);
        db_s = take_val(item_reg.den_b);
        nan  = da_s[VW] ? -na_s : na_s;
        dan  = da_s[VW] ? -da_s : da_s;
        nbn  = db_s[VW] ? -nb_s : nb_s;
        dbn  = db_s[VW] ? -db_s : db_s;
    end

    // phase 0: reduce a, 1: reduce b, 2: reduce result
    logic [63:0] cur_mag, cur_den;

    always_comb
    begin
        case (phase_reg)
            2'd0:    begin cur_mag = a_mag_reg; cur_den = a_den_reg; end
            2'd1:    begin cur_mag = b_mag_reg; cur_den = b_den_reg; end
            default: begin cur_mag = r_mag_reg; cur_den = r_den_reg; end
        endcase
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = g_x_reg;
        div_divisor  = g_y_reg;
        case (state_reg)
            S_GCD:   div_start = 1'b1;
            S_RDIV1:
            begin
                div_start    = 1'b1;
                div_dividend = cur_mag;
                div_divisor  = g_x_reg;
            end
            S_RDIV2:
            begin
                div_start    = 1'b1;
                div_dividend = cur_den;
                div_divisor  = g_x_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        mul_start = (state_reg == S_MUL);
        mul_a     = 32'(a_mag_reg);
        mul_b     = 32'(b_den_reg);
        case (mstep_reg)
            2'd0:
            begin
                mul_a = 32'(a_mag_reg);
                mul_b = (item_reg.operation == OP_MUL) ? 32'(b_mag_reg) : 32'(b_den_reg);
            end
            2'd1:
            begin
                mul_a = 32'(a_den_reg);
                mul_b = (item_reg.operation == OP_DIV) ? 32'(b_mag_reg) : 32'(b_den_reg);
            end
            default:
            begin
                mul_a = 32'(b_mag_reg);
                mul_b = 32'(a_den_reg);
            end
        endcase
    end

    logic [63:0] half_c;
    logic        bneg_eff;
    logic        lt_flag;

    assign half_c   = 64'(1) << (VW - 1);
    assign bneg_eff = (item_reg.operation == OP_SUB) ? !b_neg_reg : b_neg_reg;

    // p0 = a.mag*b.den, p1 = b.mag*a.den (add, subtract and compare)
    always_comb
    begin
        if (a_neg_reg != b_neg_reg)
            lt_flag = a_neg_reg;
        else if (a_neg_reg)
            lt_flag = p0_reg > p1_reg;
        else
            lt_flag = p0_reg < p1_reg;
    end

    always_comb
    begin
        fin_item = work_reg;
        if (phase_reg == 2'd2 && work_reg.status == ST_OK
            && item_reg.operation <= OP_DIV)
        begin
            if (r_den_reg > half_c - 64'd1
                || r_mag_reg > (r_neg_reg ? half_c : half_c - 64'd1))
                fin_item.status = ST_OVERFLOW;
            else
            begin
                fin_item.res_num = 32'(r_neg_reg ? 64'd0 - r_mag_reg : r_mag_reg);
                fin_item.res_den = 31'(r_den_reg);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_OPND;
            S_OPND:
            begin
                if (item_reg.operation > OP_EQ || da_s == '0 || db_s == '0)
                    state_next = S_OUT;
                else
                    state_next = S_GCD;
            end
            S_GCD:
            begin
                if (cur_mag == '0 || g_y_reg == '0)
                    state_next = S_RDIV1;
                else
                    state_next = S_GWAIT;
            end
            S_GWAIT:  if (div_ctl.done) state_next = S_GCD;
            S_RDIV1:  state_next = S_RWAIT1;
            S_RWAIT1: if (div_ctl.done) state_next = S_RDIV2;
            S_RDIV2:  state_next = S_RWAIT2;
            S_RWAIT2:
            begin
                if (div_ctl.done)
                begin
                    if (phase_reg == 2'd0)
                        state_next = S_GCD;
                    else if (phase_reg == 2'd1)
                    begin
                        if (item_reg.operation == OP_EQ)
                            state_next = S_OUT;
                        else if (item_reg.operation == OP_DIV && b_mag_reg == '0)
                            state_next = S_OUT;
                        else
                            state_next = S_MUL;
                    end
                    else
                        state_next = S_OUT;
                end
            end
            S_MUL:    state_next = S_MWAIT;
            S_MWAIT:
            begin
                if (mstep_reg == 2'd1 && item_reg.operation == OP_MUL)
                    state_next = S_COMB;
                else if (mstep_reg == 2'd1 && item_reg.operation == OP_DIV)
                    state_next = S_COMB;
                else if (mstep_reg == 2'd2)
                    state_next = S_COMB;
                else
                    state_next = S_MUL;
            end
            S_COMB:
            begin
                if (item_reg.operation == OP_LT)
                    state_next = S_OUT;
                else
                    state_next = S_GCD;
            end
            S_OUT:    if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    item_reg <= in_data;
                work_reg <= '0;
            end
            S_OPND:
            begin
                phase_reg <= 2'd0;
                mstep_reg <= 2'd0;
                if (item_reg.operation <= OP_EQ && (da_s == '0 || db_s == '0))
                    work_reg.status <= ST_ZERO_DEN;
                a_neg_reg <= nan[VW];
                a_mag_reg <= 64'(nan[VW] ? -nan : nan);
                a_den_reg <= 64'(dan);
                b_neg_reg <= nbn[VW];
                b_mag_reg <= 64'(nbn[VW] ? -nbn : nbn);
                b_den_reg <= 64'(dbn);
                g_x_reg   <= 64'(nan[VW] ? -nan : nan);
                g_y_reg   <= 64'(dan);
            end
            S_GWAIT:
            begin
                if (div_ctl.done)
                begin
                    g_x_reg <= g_y_reg;
                    g_y_reg <= div_r;
                end
            end
            S_RWAIT1:
            begin
                if (div_ctl.done)
                begin
                    case (phase_reg)
                        2'd0:    a_mag_reg <= (cur_mag == '0) ? cur_mag : div_q;
                        2'd1:    b_mag_reg <= (cur_mag == '0) ? cur_mag : div_q;
                        default: r_mag_reg <= (cur_mag == '0) ? cur_mag : div_q;
                    endcase
                end
            end
            S_RWAIT2:
            begin
                if (div_ctl.done)
                begin
                    case (phase_reg)
                        2'd0:
                        begin
                            if (a_mag_reg == '0)
                            begin
                                a_den_reg <= 64'd1;
                                a_neg_reg <= 1'b0;
                            end
                            else
                                a_den_reg <= div_q;
                            phase_reg <= 2'd1;
                            g_x_reg   <= b_mag_reg;
                            g_y_reg   <= b_den_reg;
                        end
                        2'd1:
                        begin
                            if (b_mag_reg == '0)
                            begin
                                b_den_reg <= 64'd1;
                                b_neg_reg <= 1'b0;
                            end
                            else
                                b_den_reg <= div_q;
                            if (item_reg.operation == OP_EQ)
                                work_reg.compare_true <= (a_neg_reg == b_neg_reg)
                                    && (a_mag_reg == b_mag_reg)
                                    && (a_den_reg == ((b_mag_reg == '0) ? 64'd1 : div_q));
                            else if (item_reg.operation == OP_DIV && b_mag_reg == '0)
                                work_reg.status <= ST_DIV_ZERO;
                        end
                        default:
                        begin
                            if (r_mag_reg == '0)
                            begin
                                r_den_reg <= 64'd1;
                                r_neg_reg <= 1'b0;
                            end
                            else
                                r_den_reg <= div_q;
                        end
                    endcase
                end
            end
            S_MWAIT:
            begin
                mstep_reg <= mstep_reg + 2'd1;
                case (mstep_reg)
                    2'd0:    p0_reg    <= mul_p;
                    2'd1:    r_den_reg <= mul_p;
                    default: p1_reg    <= mul_p;
                endcase
            end
            S_COMB:
            begin
                phase_reg <= 2'd2;
                case (item_reg.operation)
                    OP_ADD, OP_SUB:
                    begin
                        if (a_neg_reg == bneg_eff)
                        begin
                            r_neg_reg <= a_neg_reg;
                            r_mag_reg <= p0_reg + p1_reg;
                            g_x_reg   <= p0_reg + p1_reg;
                        end
                        else if (p0_reg >= p1_reg)
                        begin
                            r_neg_reg <= a_neg_reg;
                            r_mag_reg <= p0_reg - p1_reg;
                            g_x_reg   <= p0_reg - p1_reg;
                        end
                        else
                        begin
                            r_neg_reg <= bneg_eff;
                            r_mag_reg <= p1_reg - p0_reg;
                            g_x_reg   <= p1_reg - p0_reg;
                        end
                        g_y_reg <= r_den_reg;
                    end
                    OP_MUL, OP_DIV:
                    begin
                        r_neg_reg <= a_neg_reg != b_neg_reg;
                        r_mag_reg <= p0_reg;
                        g_x_reg   <= p0_reg;
                        g_y_reg   <= r_den_reg;
                    end
                    default: work_reg.compare_true <= lt_flag;
                endcase
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    out_reg <= fin_item;
            end
            default: ;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule
